FILE: rtl/turtle_symbol_interpreter_defines.svh
// ----------------------------------------------------------------------------
// Turtle symbol interpreter assertion macros
// Shared concurrent assertion wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef TURTLE_SYMBOL_INTERPRETER_DEFINES_SVH
`define TURTLE_SYMBOL_INTERPRETER_DEFINES_SVH

// checked on every clock edge outside reset
`define TSI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define TSI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/tsi_pkg.sv
// ----------------------------------------------------------------------------
// Turtle symbol interpreter package
// Widths, reset values, symbol and register codes, the quarter-wave sine
// table and the types shared by the interpreter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

   localparam int SYMBOL_BITS    = 8;
   localparam int STATUS_BITS    = 2;
   localparam int POS_BITS       = 32;
   localparam int HEADING_BITS   = 16;
   localparam int WIDTH_BITS     = 24;
   localparam int DECAY_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam int STACK_DEPTH      = 64;
   localparam int STACK_ADDR_BITS  = $clog2(STACK_DEPTH);
   localparam int STACK_COUNT_BITS = $clog2(STACK_DEPTH + 1);

   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
   localparam int QUARTER_N    = SINE_ENTRIES / 4;
   localparam int QUARTER_BITS = SINE_BITS - 2;
   localparam int TRIG_BITS    = 15;

   localparam int PROD_BITS       = WIDTH_BITS + TRIG_BITS;
   localparam int DECAY_PROD_BITS = WIDTH_BITS + DECAY_BITS + 1;

   localparam logic [PROD_BITS-1:0]    STEP_ROUND = PROD_BITS'(1) << (TRIG_BITS - 1);
   localparam logic [DECAY_BITS:0]     DECAY_ONE  = (DECAY_BITS + 1)'(1) << DECAY_BITS;

   localparam logic [POS_BITS-1:0]     POS_RESET      = '0;
   localparam logic [HEADING_BITS-1:0] HEADING_RESET  = 16'h4000;
   localparam logic [WIDTH_BITS-1:0]   WIDTH_RESET    = 24'h01_0000;
   localparam logic [HEADING_BITS-1:0] ROTATION_RESET = 16'h1000;
   localparam logic [DECAY_BITS-1:0]   DECAY_RESET    = '0;

   localparam logic [SYMBOL_BITS-1:0] SYM_PUSH       = 8'h5B;
   localparam logic [SYMBOL_BITS-1:0] SYM_POP        = 8'h5D;
   localparam logic [SYMBOL_BITS-1:0] SYM_TURN_LEFT  = 8'h2B;
   localparam logic [SYMBOL_BITS-1:0] SYM_TURN_RIGHT = 8'h2D;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_SEGMENT   = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROTATION_ANGLE = 2'd0,
      CSR_WIDTH_DECAY    = 2'd1,
      CSR_INITIAL_WIDTH  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_DRAW_Y,
      ST_DRAW_X
   } state_type;

   typedef struct packed {
      logic [POS_BITS-1:0]     x;
      logic [POS_BITS-1:0]     y;
      logic [HEADING_BITS-1:0] heading;
      logic [WIDTH_BITS-1:0]   width;
   } stack_entry_type;

   typedef struct packed {
      logic                       en;
      logic [STACK_ADDR_BITS-1:0] addr;
      stack_entry_type            data;
   } stack_wr_type;

   typedef struct packed {
      logic                       en;
      logic [STACK_ADDR_BITS-1:0] addr;
   } stack_rd_type;

   typedef struct packed {
      logic                 neg;
      logic [TRIG_BITS-1:0] mag;
   } trig_type;

   // quarter-wave table, Q2.30 Taylor series of sin, scaled to full-scale Q0.15
   localparam logic [63:0] TWO_PI_Q60    = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] HALF_Q30      = 64'd1 << 29;
   localparam logic [63:0] SINE_STEP_Q60 = TWO_PI_Q60 / SINE_ENTRIES;
   localparam logic [63:0] TRIG_SCALE    = (64'd1 << TRIG_BITS) - 64'd1;
   localparam int          TAYLOR_TERMS  = 12;
   localparam logic [63:0] TAYLOR_DIV [0:TAYLOR_TERMS-1] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef logic [TRIG_BITS-1:0] quarter_tab_type [0:QUARTER_N];

   function automatic quarter_tab_type build_quarter_tab();
      quarter_tab_type tab;
      logic [63:0]     x;
      logic [63:0]     x2;
      logic [63:0]     term;
      logic [63:0]     sum;
      logic [63:0]     v;
      for (int k = 0; k <= QUARTER_N; k++) begin
         x    = (SINE_STEP_Q60 * 64'(k) + HALF_Q30) >> 30;
         x2   = (x * x + HALF_Q30) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x2) / TAYLOR_DIV[n-1]) >> 30;
            if (n[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum * TRIG_SCALE + HALF_Q30) >> 30;
         if (v > TRIG_SCALE) begin
            v = TRIG_SCALE;
         end
         tab[k] = v[TRIG_BITS-1:0];
      end
      return tab;
   endfunction

   localparam quarter_tab_type QUARTER_TAB = build_quarter_tab();

endpackage

`default_nettype wire

FILE: rtl/tsi_stack_ram.sv
// ----------------------------------------------------------------------------
// Turtle stack memory
// Single-port-write, single-port-read synchronous RAM holding pushed turtle
// state; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_stack_ram (
   input  wire                       clock,
   input  tsi_pkg::stack_wr_type     wr,
   input  tsi_pkg::stack_rd_type     rd,
   output tsi_pkg::stack_entry_type  rd_data
);
   import tsi_pkg::*;

   stack_entry_type mem [0:STACK_DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tsi_sine_rom.sv
// ----------------------------------------------------------------------------
// Sine lookup
// Folds a full-turn table index onto the quarter-wave table and returns the
// sample as sign and unsigned Q0.15 magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_sine_rom (
   input  wire [tsi_pkg::SINE_BITS-1:0] angle_index,
   output tsi_pkg::trig_type            sample
);
   import tsi_pkg::*;

   logic [1:0]              quadrant;
   logic [QUARTER_BITS-1:0] offset;
   logic [QUARTER_BITS:0]   tab_index;

   assign quadrant = angle_index[SINE_BITS-1 -: 2];
   assign offset   = angle_index[QUARTER_BITS-1:0];

   always_comb begin
      if (quadrant[0]) begin
         tab_index = (QUARTER_BITS + 1)'(QUARTER_N) - {1'b0, offset};
      end else begin
         tab_index = {1'b0, offset};
      end
   end

   assign sample.neg = quadrant[1];
   assign sample.mag = QUARTER_TAB[tab_index];

endmodule

`default_nettype wire

FILE: rtl/turtle_symbol_interpreter.sv
// ----------------------------------------------------------------------------
// Turtle symbol interpreter
// Draw symbol: ST_DECODE, then y stepped in ST_DRAW_Y and x in ST_DRAW_X; the
// result is registered once the response slot is free, and the next symbol is
// taken only after that (one shared multiplier and sine lookup serve y then x).
// Turn and push end in ST_DECODE; pop loads stack RAM read data in ST_POP.
// Synchronous reset restores registers, position, heading, width and stack
// count at once; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_symbol_interpreter (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [tsi_pkg::SYMBOL_BITS-1:0]     req_symbol,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [tsi_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic signed [tsi_pkg::POS_BITS-1:0] rsp_start_x,
   output logic signed [tsi_pkg::POS_BITS-1:0] rsp_start_y,
   output logic signed [tsi_pkg::POS_BITS-1:0] rsp_end_x,
   output logic signed [tsi_pkg::POS_BITS-1:0] rsp_end_y,
   input  wire                                csr_write_enable,
   input  wire [tsi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [tsi_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import tsi_pkg::*;

   `include "turtle_symbol_interpreter_defines.svh"

   state_type                   state_ff, state_in;
   logic [SYMBOL_BITS-1:0]      sym_ff, sym_in;
   logic [POS_BITS-1:0]         pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]         pos_y_ff, pos_y_in;
   logic [HEADING_BITS-1:0]     heading_ff, heading_in;
   logic [WIDTH_BITS-1:0]       width_ff, width_in;
   logic [STACK_COUNT_BITS-1:0] count_ff, count_in;
   trig_type                    trig_ff, trig_in;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic                        step_neg_ff, step_neg_in;
   logic [POS_BITS-1:0]         start_y_ff, start_y_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic [POS_BITS-1:0]         rsp_start_x_ff, rsp_start_x_in;
   logic [POS_BITS-1:0]         rsp_start_y_ff, rsp_start_y_in;
   logic [POS_BITS-1:0]         rsp_end_x_ff, rsp_end_x_in;
   logic [POS_BITS-1:0]         rsp_end_y_ff, rsp_end_y_in;

   logic [HEADING_BITS-1:0]     rotation_ff;
   logic [DECAY_BITS-1:0]       decay_ff;

   stack_wr_type                stack_wr;
   stack_rd_type                stack_rd;
   stack_entry_type             stack_rd_data;

   logic [SINE_BITS-1:0]        sin_index;
   logic [SINE_BITS-1:0]        cos_index;
   logic [SINE_BITS-1:0]        trig_index;
   trig_type                    trig_lookup;
   logic [PROD_BITS-1:0]        scale_prod;
   logic [DECAY_PROD_BITS-1:0]  decay_prod;
   logic [POS_BITS-1:0]         step_mag;
   logic [POS_BITS-1:0]         x_next;
   logic [POS_BITS-1:0]         y_next;
   logic [STACK_COUNT_BITS-1:0] pop_count;
   logic                        slot_free;

   tsi_stack_ram u_stack (
      .clock   (clock),
      .wr      (stack_wr),
      .rd      (stack_rd),
      .rd_data (stack_rd_data)
   );

   tsi_sine_rom u_sine (
      .angle_index (trig_index),
      .sample      (trig_lookup)
   );

   assign sin_index  = heading_ff[HEADING_BITS-1 -: SINE_BITS];
   assign cos_index  = sin_index + SINE_BITS'(QUARTER_N);
   assign trig_index = (state_ff == ST_IDLE) ? sin_index : cos_index;

   assign scale_prod = PROD_BITS'(width_ff) * PROD_BITS'(trig_ff.mag) + STEP_ROUND;
   assign decay_prod = DECAY_PROD_BITS'(width_ff) *
                       DECAY_PROD_BITS'(DECAY_ONE - {1'b0, decay_ff});
   assign step_mag   = POS_BITS'(prod_ff[PROD_BITS-1:TRIG_BITS]);
   assign x_next     = step_neg_ff ? pos_x_ff - step_mag : pos_x_ff + step_mag;
   assign y_next     = step_neg_ff ? pos_y_ff - step_mag : pos_y_ff + step_mag;
   assign pop_count  = count_ff - STACK_COUNT_BITS'(1);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_start_x = rsp_start_x_ff;
   assign rsp_start_y = rsp_start_y_ff;
   assign rsp_end_x   = rsp_end_x_ff;
   assign rsp_end_y   = rsp_end_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= ROTATION_RESET;
         decay_ff    <= DECAY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROTATION_ANGLE: rotation_ff <= csr_write_data[HEADING_BITS-1:0];
            CSR_WIDTH_DECAY:    decay_ff    <= csr_write_data[DECAY_BITS-1:0];
            // initial width writes are ignored; reset restores the fixed default width
            CSR_INITIAL_WIDTH:  ;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= POS_RESET;
         pos_y_ff     <= POS_RESET;
         heading_ff   <= HEADING_RESET;
         width_ff     <= WIDTH_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         width_ff     <= width_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff         <= sym_in;
      trig_ff        <= trig_in;
      prod_ff        <= prod_in;
      step_neg_ff    <= step_neg_in;
      start_y_ff     <= start_y_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_start_x_ff <= rsp_start_x_in;
      rsp_start_y_ff <= rsp_start_y_in;
      rsp_end_x_ff   <= rsp_end_x_in;
      rsp_end_y_ff   <= rsp_end_y_in;
   end

   always_comb begin
      state_in       = state_ff;
      sym_in         = sym_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      heading_in     = heading_ff;
      width_in       = width_ff;
      count_in       = count_ff;
      trig_in        = trig_ff;
      prod_in        = prod_ff;
      step_neg_in    = step_neg_ff;
      start_y_in     = start_y_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_start_x_in = rsp_start_x_ff;
      rsp_start_y_in = rsp_start_y_ff;
      rsp_end_x_in   = rsp_end_x_ff;
      rsp_end_y_in   = rsp_end_y_ff;

      stack_wr.en           = 1'b0;
      stack_wr.addr         = count_ff[STACK_ADDR_BITS-1:0];
      stack_wr.data.x       = pos_x_ff;
      stack_wr.data.y       = pos_y_ff;
      stack_wr.data.heading = heading_ff;
      stack_wr.data.width   = width_ff;
      stack_rd.en           = 1'b0;
      stack_rd.addr         = pop_count[STACK_ADDR_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sym_in   = req_symbol;
               trig_in  = trig_lookup;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (sym_ff)
               SYM_TURN_LEFT: begin
                  heading_in = heading_ff + rotation_ff;
                  state_in   = ST_IDLE;
               end
               SYM_TURN_RIGHT: begin
                  heading_in = heading_ff - rotation_ff;
                  state_in   = ST_IDLE;
               end
               SYM_PUSH: begin
                  if (count_ff >= STACK_COUNT_BITS'(STACK_DEPTH)) begin
                     if (slot_free) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STATUS_OVERFLOW;
                        rsp_start_x_in = '0;
                        rsp_start_y_in = '0;
                        rsp_end_x_in   = '0;
                        rsp_end_y_in   = '0;
                        state_in       = ST_IDLE;
                     end
                  end else begin
                     stack_wr.en = 1'b1;
                     count_in    = count_ff + STACK_COUNT_BITS'(1);
                     width_in    = decay_prod[DECAY_BITS +: WIDTH_BITS];
                     state_in    = ST_IDLE;
                  end
               end
               SYM_POP: begin
                  if (count_ff == '0) begin
                     if (slot_free) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STATUS_UNDERFLOW;
                        rsp_start_x_in = '0;
                        rsp_start_y_in = '0;
                        rsp_end_x_in   = '0;
                        rsp_end_y_in   = '0;
                        state_in       = ST_IDLE;
                     end
                  end else begin
                     stack_rd.en = 1'b1;
                     count_in    = pop_count;
                     state_in    = ST_POP;
                  end
               end
               default: begin
                  prod_in     = scale_prod;
                  step_neg_in = trig_ff.neg;
                  trig_in     = trig_lookup;
                  state_in    = ST_DRAW_Y;
               end
            endcase
         end

         ST_POP: begin
            pos_x_in   = stack_rd_data.x;
            pos_y_in   = stack_rd_data.y;
            heading_in = stack_rd_data.heading;
            width_in   = stack_rd_data.width;
            state_in   = ST_IDLE;
         end

         ST_DRAW_Y: begin
            start_y_in  = pos_y_ff;
            pos_y_in    = y_next;
            prod_in     = scale_prod;
            step_neg_in = trig_ff.neg;
            state_in    = ST_DRAW_X;
         end

         ST_DRAW_X: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_SEGMENT;
               rsp_start_x_in = pos_x_ff;
               rsp_start_y_in = start_y_ff;
               rsp_end_x_in   = x_next;
               rsp_end_y_in   = pos_y_ff;
               pos_x_in       = x_next;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `TSI_ASSERT(a_count_bound, count_ff <= STACK_COUNT_BITS'(STACK_DEPTH), "stack count beyond depth")
   `TSI_ASSERT(a_ram_no_collision, !(stack_wr.en && stack_rd.en), "stack read and write together")
   `TSI_ASSERT(a_pop_after_read, (state_ff == ST_POP) |-> $past(stack_rd.en), "pop load without RAM read")
   `TSI_ASSERT(a_heading_source, $past(reset) || $stable(heading_ff) || $past(state_ff) == ST_DECODE || $past(state_ff) == ST_POP, "heading changed outside turn or pop")

endmodule

`default_nettype wire
